FILE: rtl/mng_pkg.sv
package mng_pkg;

   localparam int NUM_KEYS = 15;

   // Request kinds carried by req_type.
   localparam logic REQ_MIDI = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // MIDI status bytes that act.
   localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;

   // Key indexes whose action is not a button bit.
   localparam int KEY_HAT_DOWN  = 2;
   localparam int KEY_HAT_LEFT  = 4;
   localparam int KEY_HAT_UP    = 6;
   localparam int KEY_HAT_RIGHT = 8;
   localparam int KEY_LSX_LEFT  = 12;
   localparam int KEY_RSX_LEFT  = 13;
   localparam int KEY_LSX_RIGHT = 14;

   localparam logic [3:0] HAT_NEUTRAL = 4'd8;
   localparam logic [3:0] HAT_DOWN    = 4'd4;
   localparam logic [3:0] HAT_LEFT    = 4'd6;
   localparam logic [3:0] HAT_UP      = 4'd0;
   localparam logic [3:0] HAT_RIGHT   = 4'd2;

   localparam logic [7:0] STICK_CENTER = 8'd128;
   localparam logic [7:0] STICK_MIN    = 8'd0;
   localparam logic [7:0] STICK_MAX    = 8'd255;

   localparam logic [7:0] HOLD_TICKS_RESET = 8'd8;

   localparam int REPORT_BITS = 56;
   localparam int BEATS       = 8;

   typedef struct packed {
      logic       req_type;
      logic [7:0] midi_status;
      logic [6:0] midi_note;
      logic [6:0] midi_velocity;
   } item_type;

   typedef struct packed {
      logic [15:0] button_bits;
      logic [3:0]  hat_value;
      logic [7:0]  left_stick_x;
      logic [7:0]  right_stick_x;
   } report_type;

   // Note number assigned to each key.
   function automatic logic [6:0] key_note(input int k);
      case (k)
         0:       key_note = 7'd60;
         1:       key_note = 7'd62;
         2:       key_note = 7'd64;
         3:       key_note = 7'd65;
         4:       key_note = 7'd67;
         5:       key_note = 7'd69;
         6:       key_note = 7'd71;
         7:       key_note = 7'd72;
         8:       key_note = 7'd74;
         9:       key_note = 7'd76;
         10:      key_note = 7'd77;
         11:      key_note = 7'd79;
         12:      key_note = 7'd81;
         13:      key_note = 7'd83;
         14:      key_note = 7'd84;
         default: key_note = 7'd0;
      endcase
   endfunction

   // Button bit driven by a key; zero for hat and stick keys.
   function automatic logic [15:0] key_button_mask(input int k);
      case (k)
         0:       key_button_mask = 16'h0040;
         1:       key_button_mask = 16'h0080;
         3:       key_button_mask = 16'h0002;
         5:       key_button_mask = 16'h0001;
         7:       key_button_mask = 16'h0008;
         9:       key_button_mask = 16'h0004;
         10:      key_button_mask = 16'h0010;
         11:      key_button_mask = 16'h0020;
         default: key_button_mask = 16'h0000;
      endcase
   endfunction

   // Report bytes in sent order, most significant first.
   function automatic logic [REPORT_BITS-1:0] report_stream(input report_type r);
      report_stream = {r.button_bits[7:0], r.button_bits[15:8], 4'd0, r.hat_value,
                       r.left_stick_x, STICK_CENTER, r.right_stick_x, STICK_CENTER};
   endfunction

endpackage

FILE: rtl/mng_key_engine.sv
module mng_key_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  mng_pkg::item_type   item,
   input  logic [7:0]          hold_ticks,
   output mng_pkg::report_type report
);

   logic [mng_pkg::NUM_KEYS-1:0] down_ff, down_in;
   logic [mng_pkg::NUM_KEYS-1:0] up_ff, up_in;
   logic [mng_pkg::NUM_KEYS-1:0] pressed_ff, pressed_in;
   logic [7:0]                   count_ff [mng_pkg::NUM_KEYS];
   logic [7:0]                   count_in [mng_pkg::NUM_KEYS];
   mng_pkg::report_type          report_ff, report_in;

   logic                         note_off, note_on;
   logic [mng_pkg::NUM_KEYS-1:0] note_hit;
   logic [mng_pkg::NUM_KEYS-1:0] pressed_t, clr, busy, cand, fire;
   logic [7:0]                   count_a [mng_pkg::NUM_KEYS];
   logic [7:0]                   count_b [mng_pkg::NUM_KEYS];
   logic [mng_pkg::NUM_KEYS-1:0] seen;
   logic [15:0]                  btn_clr, btn_set;
   logic                         idle;

   assign report = report_ff;

   always_comb begin
      note_off = (item.midi_status == mng_pkg::STATUS_NOTE_OFF) ||
                 ((item.midi_status == mng_pkg::STATUS_NOTE_ON) && (item.midi_velocity == 7'd0));
      note_on  = (item.midi_status == mng_pkg::STATUS_NOTE_ON) && (item.midi_velocity != 7'd0);

      // Tick: apply latched events, advance the running counters.
      btn_clr = 16'h0000;
      for (int i = 0; i < mng_pkg::NUM_KEYS; i++) begin
         note_hit[i]  = (item.midi_note == mng_pkg::key_note(i));
         pressed_t[i] = up_ff[i] ? 1'b0 : (down_ff[i] ? 1'b1 : pressed_ff[i]);
         count_a[i]   = (!up_ff[i] && down_ff[i]) ? 8'd0 : count_ff[i];
         count_b[i]   = (count_a[i] != 8'd0) ? count_a[i] + 8'd1 : count_a[i];
         clr[i]       = (count_a[i] != 8'd0) && (count_b[i] == hold_ticks);
         busy[i]      = (count_b[i] != 8'd0) && (count_b[i] < hold_ticks);
         cand[i]      = pressed_t[i] && (count_b[i] == 8'd0);
         if (clr[i]) begin
            btn_clr = btn_clr | mng_pkg::key_button_mask(i);
         end
      end
      idle = (busy == '0);

      // The first pressed idle key fires, and only while no hold is running.
      seen    = '0;
      btn_set = 16'h0000;
      for (int i = 0; i < mng_pkg::NUM_KEYS; i++) begin
         if (i == 0) begin
            fire[i] = idle && cand[i];
            seen[i] = cand[i];
         end else begin
            fire[i] = idle && cand[i] && !seen[i-1];
            seen[i] = cand[i] || seen[i-1];
         end
         if (fire[i]) begin
            btn_set = btn_set | mng_pkg::key_button_mask(i);
         end
      end

      down_in    = down_ff;
      up_in      = up_ff;
      pressed_in = pressed_ff;
      count_in   = count_ff;
      report_in  = report_ff;

      if (go && (item.req_type == mng_pkg::REQ_MIDI)) begin
         if (note_off || note_on) begin
            for (int i = 0; i < mng_pkg::NUM_KEYS; i++) begin
               if (note_hit[i]) begin
                  up_in[i]   = note_off;
                  down_in[i] = note_on;
               end
            end
         end
      end else if (go) begin
         down_in    = '0;
         up_in      = '0;
         pressed_in = pressed_t;
         for (int i = 0; i < mng_pkg::NUM_KEYS; i++) begin
            count_in[i] = fire[i] ? 8'd1 : count_b[i];
         end

         report_in.button_bits = (report_ff.button_bits & ~btn_clr) | btn_set;

         if (fire[mng_pkg::KEY_HAT_DOWN]) begin
            report_in.hat_value = mng_pkg::HAT_DOWN;
         end else if (fire[mng_pkg::KEY_HAT_LEFT]) begin
            report_in.hat_value = mng_pkg::HAT_LEFT;
         end else if (fire[mng_pkg::KEY_HAT_UP]) begin
            report_in.hat_value = mng_pkg::HAT_UP;
         end else if (fire[mng_pkg::KEY_HAT_RIGHT]) begin
            report_in.hat_value = mng_pkg::HAT_RIGHT;
         end else if (clr[mng_pkg::KEY_HAT_DOWN] || clr[mng_pkg::KEY_HAT_LEFT] ||
                      clr[mng_pkg::KEY_HAT_UP] || clr[mng_pkg::KEY_HAT_RIGHT]) begin
            report_in.hat_value = mng_pkg::HAT_NEUTRAL;
         end

         if (fire[mng_pkg::KEY_LSX_LEFT]) begin
            report_in.left_stick_x = mng_pkg::STICK_MIN;
         end else if (fire[mng_pkg::KEY_LSX_RIGHT]) begin
            report_in.left_stick_x = mng_pkg::STICK_MAX;
         end else if (clr[mng_pkg::KEY_LSX_LEFT] || clr[mng_pkg::KEY_LSX_RIGHT]) begin
            report_in.left_stick_x = mng_pkg::STICK_CENTER;
         end

         if (fire[mng_pkg::KEY_RSX_LEFT]) begin
            report_in.right_stick_x = mng_pkg::STICK_MIN;
         end else if (clr[mng_pkg::KEY_RSX_LEFT]) begin
            report_in.right_stick_x = mng_pkg::STICK_CENTER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff    <= '0;
         up_ff      <= '0;
         pressed_ff <= '0;
         for (int i = 0; i < mng_pkg::NUM_KEYS; i++) begin
            count_ff[i] <= 8'd0;
         end
         report_ff.button_bits   <= 16'h0000;
         report_ff.hat_value     <= mng_pkg::HAT_NEUTRAL;
         report_ff.left_stick_x  <= mng_pkg::STICK_CENTER;
         report_ff.right_stick_x <= mng_pkg::STICK_CENTER;
      end else begin
         down_ff    <= down_in;
         up_ff      <= up_in;
         pressed_ff <= pressed_in;
         count_ff   <= count_in;
         report_ff  <= report_in;
      end
   end

endmodule

FILE: rtl/mng_serializer.sv
module mng_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mng_pkg::report_type report,
   output logic                can_load,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_serial_byte,
   output logic                rsp_last_byte
);

   localparam int CW = $clog2(mng_pkg::BEATS);
   localparam logic [CW-1:0] LAST_BEAT = CW'(mng_pkg::BEATS - 1);

   logic [mng_pkg::REPORT_BITS-1:0] shift_ff, shift_in;
   logic [CW-1:0]                   beat_ff, beat_in;
   logic                            busy_ff, busy_in;
   logic                            taken;

   assign taken           = busy_ff && !rsp_stall;
   assign can_load        = !busy_ff || (taken && (beat_ff == LAST_BEAT));
   assign rsp_valid       = busy_ff;
   assign rsp_last_byte   = (beat_ff == LAST_BEAT);
   assign rsp_serial_byte = {(beat_ff == '0),
                             shift_ff[mng_pkg::REPORT_BITS-1 -: 7]};

   always_comb begin
      shift_in = shift_ff;
      beat_in  = beat_ff;
      busy_in  = busy_ff;
      if (load) begin
         shift_in = mng_pkg::report_stream(report);
         beat_in  = '0;
         busy_in  = 1'b1;
      end else if (taken) begin
         shift_in = shift_ff << 7;
         beat_in  = beat_ff + CW'(1);
         if (beat_ff == LAST_BEAT) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         beat_ff <= beat_in;
      end
      shift_ff <= shift_in;
   end

endmodule

FILE: rtl/midi_note_to_gamepad_report.sv
// MIDI note to gamepad report. Request beats are either MIDI short messages or
// periodic ticks. Note-on and note-off for fifteen fixed notes (60 to 84, white
// keys) latch a down or up event per key; each tick applies those events, runs
// the per-key hold counters, fires the first pressed idle key when no hold is in
// progress, and then sends the seven-byte report as eight 7-bit beats on the rsp
// channel, the first with bit 7 set and the eighth flagged by rsp_last_byte. A
// MIDI message produces no beat. Every accepted MIDI message is processed in the
// cycle after it is taken, so MIDI messages go through at one per cycle while no
// tick waits in the request register. The serializer loads the new report in
// the cycle after the tick is processed. A tick occupies the serializer for
// eight beats, and the serializer goes idle between consecutive reports; the
// next tick waits in the request register until the final beat of the current
// report is taken. hold_ticks is written through the csr channel, which is
// always ready, and resets to 8.
module midi_note_to_gamepad_report (
   input  logic       clock,
   input  logic       reset,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_hold_ticks,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_type,
   input  logic [7:0] req_midi_status,
   input  logic [6:0] req_midi_note,
   input  logic [6:0] req_midi_velocity,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_serial_byte,
   output logic       rsp_last_byte
);

   // Configuration register.
   logic [7:0] hold_ticks_ff, hold_ticks_in;

   // Request register: one beat waits here until the engine can take it.
   mng_pkg::item_type item_ff, item_in;
   logic              item_valid_ff, item_valid_in;

   logic                req_accept;
   logic                go;
   logic                ser_can_load;
   mng_pkg::report_type report;

   assign csr_ready = 1'b1;

   // A MIDI message only touches the event latches, so it never waits. A tick
   // hands a fresh report to the serializer and needs it free or finishing.
   assign go = item_valid_ff &&
               ((item_ff.req_type == mng_pkg::REQ_MIDI) || ser_can_load);

   // The request register refills in the same cycle it drains.
   assign req_stall  = item_valid_ff && !go;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      hold_ticks_in = hold_ticks_ff;
      if (csr_valid && csr_ready) begin
         hold_ticks_in = csr_hold_ticks;
      end

      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (req_accept) begin
         item_in.req_type      = req_type;
         item_in.midi_status   = req_midi_status;
         item_in.midi_note     = req_midi_note;
         item_in.midi_velocity = req_midi_velocity;
         item_valid_in         = 1'b1;
      end else if (go) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= mng_pkg::HOLD_TICKS_RESET;
         item_valid_ff <= 1'b0;
      end else begin
         hold_ticks_ff <= hold_ticks_in;
         item_valid_ff <= item_valid_in;
      end
      item_ff <= item_in;
   end

   // Key state and report values; the report register updates on the tick.
   mng_key_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .item       (item_ff),
      .hold_ticks (hold_ticks_ff),
      .report     (report)
   );

   // The serializer loads in the cycle after the tick, when the new report has
   // settled in the engine's register.
   logic tick_go_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_go_ff <= 1'b0;
      end else begin
         tick_go_ff <= go && (item_ff.req_type == mng_pkg::REQ_TICK);
      end
   end

   logic ser_can_load_raw;

   // While a load is pending, the serializer is not free for another tick.
   assign ser_can_load = ser_can_load_raw && !tick_go_ff;

   mng_serializer u_serializer (
      .clock           (clock),
      .reset           (reset),
      .load            (tick_go_ff),
      .report          (report),
      .can_load        (ser_can_load_raw),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_serial_byte (rsp_serial_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

   // A beat in the middle of a report is followed by the rest of that report.
   a_report_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_byte |=> rsp_valid && !rsp_serial_byte[7])
      else $error("report beat sequence broken");

   // The first beat of a report is never its last.
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_serial_byte[7] |-> !rsp_last_byte)
      else $error("first beat flagged as last");

   // Back-pressure on requests only ever comes from a waiting tick.
   a_stall_has_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid_ff && (item_ff.req_type == mng_pkg::REQ_TICK))
      else $error("request stalled without a waiting tick");

   // A configuration write lands in the hold register.
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> hold_ticks_ff == $past(csr_hold_ticks))
      else $error("hold_ticks write lost");

endmodule

FILE: tb/gamepad_report_checker.sv
module gamepad_report_checker
   import mng_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [7:0] csr_hold_ticks,

   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_type,
   input  logic [7:0] req_midi_status,
   input  logic [6:0] req_midi_note,
   input  logic [6:0] req_midi_velocity,

   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_serial_byte,
   input  logic       rsp_last_byte,

   output int         mismatch_count,
   output int         beats_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] serial_byte;
      logic       last_byte;
   } beat_type;

   // Note number of each key, key 0 in the low bits.
   localparam logic [NUM_KEYS*7-1:0] NOTE_MAP = {
      7'd84, 7'd83, 7'd81, 7'd79, 7'd77, 7'd76, 7'd74, 7'd72,
      7'd71, 7'd69, 7'd67, 7'd65, 7'd64, 7'd62, 7'd60};

   // Button bit of each key; hat and stick keys carry none.
   localparam logic [NUM_KEYS*16-1:0] BUTTON_MAP = {
      16'h0000, 16'h0000, 16'h0000, 16'h0020, 16'h0010, 16'h0004, 16'h0000, 16'h0008,
      16'h0000, 16'h0001, 16'h0000, 16'h0002, 16'h0000, 16'h0080, 16'h0040};

   logic [7:0]          hold_limit;
   logic [NUM_KEYS-1:0] down_latched;
   logic [NUM_KEYS-1:0] up_latched;
   logic [NUM_KEYS-1:0] held;
   logic [7:0]          hold_count [NUM_KEYS];
   logic [15:0]         buttons;
   logic [3:0]          hat;
   logic [7:0]          stick_l;
   logic [7:0]          stick_r;
   beat_type            expected_beats [$];

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic clear_state();
      hold_limit   = HOLD_TICKS_RESET;
      down_latched = '0;
      up_latched   = '0;
      held         = '0;
      for (int k = 0; k < NUM_KEYS; k++)
         hold_count[k] = 8'd0;
      buttons = 16'h0000;
      hat     = HAT_NEUTRAL;
      stick_l = STICK_CENTER;
      stick_r = STICK_CENTER;
      expected_beats.delete();
   endtask

   // Sets or clears the report value that a key controls.
   task automatic drive_key(input int k, input bit engage);
      case (k)
         KEY_HAT_DOWN:  hat = engage ? HAT_DOWN : HAT_NEUTRAL;
         KEY_HAT_LEFT:  hat = engage ? HAT_LEFT : HAT_NEUTRAL;
         KEY_HAT_UP:    hat = engage ? HAT_UP : HAT_NEUTRAL;
         KEY_HAT_RIGHT: hat = engage ? HAT_RIGHT : HAT_NEUTRAL;
         KEY_LSX_LEFT:  stick_l = engage ? STICK_MIN : STICK_CENTER;
         KEY_RSX_LEFT:  stick_r = engage ? STICK_MIN : STICK_CENTER;
         KEY_LSX_RIGHT: stick_l = engage ? STICK_MAX : STICK_CENTER;
         default: begin
            if (engage)
               buttons = buttons | BUTTON_MAP[k*16 +: 16];
            else
               buttons = buttons & ~BUTTON_MAP[k*16 +: 16];
         end
      endcase
   endtask

   task automatic latch_note(input logic [7:0] status, input logic [6:0] note,
                             input logic [6:0] velocity);
      bit off_msg;
      bit on_msg;
      off_msg = (status == STATUS_NOTE_OFF) || (status == STATUS_NOTE_ON && velocity == 7'd0);
      on_msg  = (status == STATUS_NOTE_ON) && velocity != 7'd0;
      if (off_msg || on_msg) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (NOTE_MAP[k*7 +: 7] == note) begin
               up_latched[k]   = off_msg;
               down_latched[k] = on_msg;
            end
         end
      end
   endtask

   // One tick: apply latched events, run the hold counters, maybe fire a key,
   // and queue the eight beats of the resulting report.
   task automatic run_tick();
      bit          idle;
      bit          fired;
      logic [55:0] stream;
      beat_type    beat;
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (up_latched[k]) begin
            held[k] = 1'b0;
         end else if (down_latched[k]) begin
            held[k]       = 1'b1;
            hold_count[k] = 8'd0;
         end
      end
      up_latched   = '0;
      down_latched = '0;

      for (int k = 0; k < NUM_KEYS; k++) begin
         if (hold_count[k] != 8'd0) begin
            hold_count[k] = hold_count[k] + 8'd1;
            if (hold_count[k] == hold_limit)
               drive_key(k, 1'b0);
         end
      end

      idle = 1'b1;
      for (int k = 0; k < NUM_KEYS; k++)
         if (hold_count[k] != 8'd0 && hold_count[k] < hold_limit)
            idle = 1'b0;
      fired = 1'b0;
      if (idle) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (!fired && held[k] && hold_count[k] == 8'd0) begin
               drive_key(k, 1'b1);
               hold_count[k] = 8'd1;
               fired         = 1'b1;
            end
         end
      end

      stream = {buttons[7:0], buttons[15:8], 4'd0, hat,
                stick_l, STICK_CENTER, stick_r, STICK_CENTER};
      for (int b = 0; b < BEATS; b++) begin
         beat.serial_byte = {b == 0, stream[55-7*b -: 7]};
         beat.last_byte   = (b == BEATS - 1);
         expected_beats.push_back(beat);
      end
   endtask

   always @(posedge clock) begin : watch
      beat_type want;
      if (reset) begin
         clear_state();
      end else begin
         if (csr_valid && csr_ready)
            hold_limit = csr_hold_ticks;
         if (req_valid && !req_stall) begin
            if (req_type == REQ_TICK)
               run_tick();
            else
               latch_note(req_midi_status, req_midi_note, req_midi_velocity);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               report_mismatch($sformatf("unexpected beat serial_byte=%02h last_byte=%0b",
                                         rsp_serial_byte, rsp_last_byte));
            end else begin
               want = expected_beats.pop_front();
               if (rsp_serial_byte !== want.serial_byte)
                  report_mismatch($sformatf("serial_byte got %02h want %02h",
                                            rsp_serial_byte, want.serial_byte));
               if (rsp_last_byte !== want.last_byte)
                  report_mismatch($sformatf("last_byte got %0b want %0b",
                                            rsp_last_byte, want.last_byte));
            end
         end
      end
      beats_owed <= expected_beats.size();
   end

endmodule

FILE: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mng_pkg::*;

   // Cycles without any handshake on any channel before the run is declared hung.
   // The longest legal quiet stretch is the deliberate receiver hold-off below.
   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 90;

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_hold_ticks = 8'd0;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_type = REQ_MIDI;
   logic [7:0] req_midi_status = 8'd0;
   logic [6:0] req_midi_note = 7'd0;
   logic [6:0] req_midi_velocity = 7'd0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_serial_byte;
   logic       rsp_last_byte;

   int mismatches;
   int beats_owed;

   // When steady is set neither side inserts random bubbles.
   bit steady = 1'b0;
   // Each increment asks the receiver for one long hold-off.
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   midi_note_to_gamepad_report DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_hold_ticks    (csr_hold_ticks),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_midi_status   (req_midi_status),
      .req_midi_note     (req_midi_note),
      .req_midi_velocity (req_midi_velocity),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_serial_byte   (rsp_serial_byte),
      .rsp_last_byte     (rsp_last_byte)
   );

   gamepad_report_checker report_check (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_hold_ticks    (csr_hold_ticks),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_midi_status   (req_midi_status),
      .req_midi_note     (req_midi_note),
      .req_midi_velocity (req_midi_velocity),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_serial_byte   (rsp_serial_byte),
      .rsp_last_byte     (rsp_last_byte),
      .mismatch_count    (mismatches),
      .beats_owed        (beats_owed)
   );

   // Receiver side. It stalls at random about a third of the time, except while
   // steady is set. When the stimulus asks for a long hold-off, this process
   // counts it out by itself so the sender can keep offering ticks meanwhile.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 32);
         end
      end
   end

   // Watchdog: any accepted beat on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one request beat and holds it until it is taken. Afterwards the
   // sender may drop valid and idle at random. If it does not, valid stays high and the
   // caller either offers the next beat in the same step or calls drain.
   task automatic offer(input logic kind, input logic [7:0] status,
                        input logic [6:0] note, input logic [6:0] velocity);
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_midi_status   <= status;
      req_midi_note     <= note;
      req_midi_velocity <= velocity;
      do
         @(posedge clock);
      while (req_stall);
      while (!steady && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Tick payload fields carry no meaning, so they get random content.
   task automatic tick();
      offer(REQ_TICK, 8'($urandom), 7'($urandom), 7'($urandom));
   endtask

   task automatic press(input int k, input logic [6:0] velocity);
      offer(REQ_MIDI, STATUS_NOTE_ON, key_note(k), velocity);
   endtask

   task automatic lift(input int k);
      offer(REQ_MIDI, STATUS_NOTE_OFF, key_note(k), 7'($urandom));
   endtask

   // Stops offering and waits until every expected beat has come back. The
   // first edge lets the checker count a tick taken in this very step. The
   // short pause after that covers a MIDI message still being absorbed.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_owed != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_hold(input logic [7:0] value);
      drain();
      csr_valid      <= 1'b1;
      csr_hold_ticks <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed note traffic on the fifteen keys mixed with ticks; the
   // rest is off-key or foreign-status noise. acts tells whether the block can
   // react to the beat at all.
   task automatic random_item(output bit acts);
      int         pick;
      int         k;
      logic       kind;
      logic [7:0] status;
      logic [6:0] note;
      logic [6:0] velocity;
      pick     = $urandom_range(99);
      k        = $urandom_range(NUM_KEYS - 1);
      kind     = REQ_MIDI;
      status   = STATUS_NOTE_ON;
      note     = key_note(k);
      velocity = 7'($urandom_range(1, 127));
      if (pick < 40) begin
         kind = REQ_TICK;
      end else if (pick < 65) begin
         status = STATUS_NOTE_ON;
      end else if (pick < 75) begin
         status   = STATUS_NOTE_OFF;
         velocity = 7'($urandom);
      end else if (pick < 85) begin
         velocity = 7'd0;
      end else if (pick < 93) begin
         status   = 8'($urandom);
         velocity = 7'($urandom);
      end else begin
         status   = 8'($urandom);
         note     = 7'($urandom);
         velocity = 7'($urandom);
      end
      acts = (kind == REQ_TICK);
      if (status == STATUS_NOTE_ON || status == STATUS_NOTE_OFF)
         for (int j = 0; j < NUM_KEYS; j++)
            if (key_note(j) == note)
               acts = 1'b1;
      if (kind == REQ_TICK)
         tick();
      else
         offer(REQ_MIDI, status, note, velocity);
   endtask

   initial begin
      bit acts;
      int count;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the hold time still at its reset value of eight.
      // The first tick must report the neutral pad.
      tick();
      press(0, 7'd127);
      tick();
      // Down then up on the same key before a tick: only the up survives.
      press(1, 7'd1);
      lift(1);
      // Up (as note-on with zero velocity) then down: the down survives.
      offer(REQ_MIDI, STATUS_NOTE_ON, key_note(13), 7'd0);
      press(13, 7'd127);
      press(14, 7'd64);
      // Beats the block must ignore: an off-table note and foreign statuses.
      offer(REQ_MIDI, STATUS_NOTE_ON, 7'd61, 7'd100);
      offer(REQ_MIDI, 8'hA0, key_note(2), 7'd127);
      offer(REQ_MIDI, 8'hFF, 7'd127, 7'd127);
      offer(REQ_MIDI, 8'h00, 7'd0, 7'd0);
      // Release key 0 through a zero-velocity note-on.
      offer(REQ_MIDI, STATUS_NOTE_ON, key_note(0), 7'd0);
      // Enough ticks for the first hold to expire and the next keys to fire.
      repeat (10) tick();

      // Random traffic under a few hold settings. A hold of one never expires
      // by count, so every tick may fire another pressed key. The middle phase
      // starts with a stretch in which neither side idles.
      for (int phase = 0; phase < 3; phase++) begin
         write_hold(phase == 0 ? 8'd1 : 8'($urandom_range(2, 12)));
         count = 0;
         while (count < 45) begin
            steady <= (phase == 1 && count < 30);
            random_item(acts);
            if (acts)
               count++;
         end
      end
      steady <= 1'b0;

      // Longest hold: one key fires and keeps its value through this stretch.
      // Early on the receiver holds off for a long stretch while ticks keep
      // coming, which backs the block up until it stalls its request side.
      write_hold(8'd255);
      press(5, 7'd90);
      for (int n = 0; n < 12; n++) begin
         if (n == 3)
            hold_asks <= hold_asks + 1;
         tick();
      end

      // Hold of zero: no counter ever blocks firing, so each tick fires the next
      // pressed key, and a counter wrapping to zero would clear its value.
      write_hold(8'd0);
      press(2, 7'd33);
      press(12, 7'd127);
      press(7, 7'd5);
      repeat (4) tick();
      lift(2);
      repeat (2) tick();

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && beats_owed == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
